/* design/bdoc_pkg.sv */
// shared types and constants for the block diagonal occupancy counter
// used by bdoc_ctrl, bdoc_dpath and block_diagonal_occupancy_counter_core
package bdoc_pkg;

	localparam int DEF_MAX_BLOCKS  = 1024;
	localparam int DEF_MAX_COLUMNS = 65536;

	localparam int IDX_W       = 16;
	localparam int VAL_W       = 17;
	localparam int ROW_W       = 16;
	localparam int COL_W       = 16;
	localparam int OP_W        = 2;
	localparam int DIAG_W      = 10;
	localparam int RB_W        = 10;
	localparam int COUNT_W     = 32;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 56;

	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_END = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD_COL = 2'd2;
	localparam logic [OP_W-1:0] OP_ENTRY    = 2'd3;

	localparam logic [1:0] RES_PLAIN   = 2'd0;
	localparam logic [1:0] RES_PTR_ERR = 2'd1;
	localparam logic [1:0] RES_L_ERR   = 2'd2;
	localparam logic [1:0] RES_OK      = 2'd3;

	typedef struct packed {
		logic       latch;
		logic       scan_step;
		logic       look;
		logic       upd;
		logic       clr_step;
		logic       set_ptr;
		logic       emit;
		logic [1:0] res_kind;
	} bdoc_cmd_t;

	typedef struct packed {
		logic found;
		logic last_blk;
		logic col_bad;
		logic neg;
		logic clr_done;
	} bdoc_stat_t;

endpackage

/* design/bdoc_ctrl.sv */
// controller state machine for the block diagonal occupancy counter
// depends on bdoc_pkg; drives bdoc_dpath through command and status structs
module bdoc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [bdoc_pkg::OP_W-1:0] in_op,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  bdoc_pkg::bdoc_stat_t      stat,
	output bdoc_pkg::bdoc_cmd_t       cmd
);
	import bdoc_pkg::*;

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_CLR  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       free;

	assign free      = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					unique case (in_op)
						OP_CLEAR: state_d = S_CLR;
						OP_ENTRY: state_d = S_SCAN;
						default:  state_d = S_FIN;
					endcase
				end
			end
			S_SCAN: begin
				if (!stat.found) begin
					if (stat.last_blk) begin
						if (free) begin
							cmd.emit     = 1'b1;
							cmd.res_kind = RES_PTR_ERR;
							state_d      = S_IDLE;
						end
					end else begin
						cmd.scan_step = 1'b1;
					end
				end else if (stat.col_bad) begin
					if (free) begin
						cmd.emit     = 1'b1;
						cmd.res_kind = RES_PTR_ERR;
						state_d      = S_IDLE;
					end
				end else if (stat.neg) begin
					if (free) begin
						cmd.emit     = 1'b1;
						cmd.set_ptr  = 1'b1;
						cmd.res_kind = RES_L_ERR;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.look    = 1'b1;
					cmd.set_ptr = 1'b1;
					state_d     = S_UPD;
				end
			end
			S_UPD: begin
				if (free) begin
					cmd.upd      = 1'b1;
					cmd.emit     = 1'b1;
					cmd.res_kind = RES_OK;
					state_d      = S_IDLE;
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (free) begin
					cmd.emit     = 1'b1;
					cmd.res_kind = RES_PLAIN;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/bdoc_dpath.sv */
// datapath: row-block end table, column table, diagonal store, pointers and count
// depends on bdoc_pkg; sequenced by bdoc_ctrl
module bdoc_dpath #(
	parameter int MAX_BLOCKS  = bdoc_pkg::DEF_MAX_BLOCKS,
	parameter int MAX_COLUMNS = bdoc_pkg::DEF_MAX_COLUMNS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [bdoc_pkg::OP_W-1:0]        in_op,
	input  logic [bdoc_pkg::IDX_W-1:0]       in_index,
	input  logic [bdoc_pkg::VAL_W-1:0]       in_value,
	input  logic [bdoc_pkg::ROW_W-1:0]       in_row,
	input  logic [bdoc_pkg::COL_W-1:0]       in_column,
	input  bdoc_pkg::bdoc_cmd_t              cmd,
	output bdoc_pkg::bdoc_stat_t             stat,
	output logic [bdoc_pkg::OUT_TDATA_W-1:0] out_data
);
	import bdoc_pkg::*;

	localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CD = (MAX_COLUMNS > (1 << COL_W)) ? (1 << COL_W) : MAX_COLUMNS;
	localparam int CW = (CD > 1) ? $clog2(CD) : 1;
	localparam logic [BW-1:0] LAST_BLK = BW'(MAX_BLOCKS - 1);

	logic [VAL_W-1:0] rbe_mem  [MAX_BLOCKS];
	logic [BW-1:0]    cb_mem   [CD];
	logic [BW:0]      last_mem [MAX_BLOCKS];

	logic [VAL_W-1:0] rbe_rd_q;
	logic [BW-1:0]    cb_rd_q;
	logic [BW:0]      last_rd_q;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [BW-1:0]    l_q;
	logic [BW-1:0]    k_q;
	logic [BW-1:0]    ptr_q;
	logic [BW-1:0]    clr_addr_q;
	logic [COUNT_W-1:0] count_q;

	logic [BW-1:0]      rbe_raddr;
	logic [BW-1:0]      k_d;
	logic               is_new;
	logic [COUNT_W-1:0] count_d;
	logic               wr_end, wr_col;

	logic               nb_q, err_q;
	logic [DIAG_W-1:0]  diag_q;
	logic [RB_W-1:0]    rb_q;
	logic [COUNT_W-1:0] cnt_out_q;

	assign wr_end = cmd.latch && (in_op == OP_LOAD_END)
		&& (32'(in_index) < 32'(MAX_BLOCKS));
	assign wr_col = cmd.latch && (in_op == OP_LOAD_COL)
		&& (32'(in_index) < 32'(MAX_COLUMNS)) && (32'(in_value) < 32'(MAX_BLOCKS));

	assign rbe_raddr = cmd.latch ? ptr_q : l_q + BW'(1);
	assign k_d       = cb_rd_q - l_q;
	assign is_new    = !last_rd_q[BW] || (last_rd_q[BW-1:0] != l_q);
	assign count_d   = !is_new ? count_q : ((&count_q) ? count_q : count_q + 1'b1);

	assign stat.found    = rbe_rd_q > {1'b0, row_q};
	assign stat.last_blk = (l_q == LAST_BLK);
	assign stat.col_bad  = 32'(col_q) >= 32'(MAX_COLUMNS);
	assign stat.neg      = cb_rd_q < l_q;
	assign stat.clr_done = (clr_addr_q == LAST_BLK);

	// row-block end table
	always_ff @(posedge clk) begin
		if (wr_end) begin
			rbe_mem[in_index[BW-1:0]] <= in_value;
		end
		if (cmd.latch || cmd.scan_step) begin
			rbe_rd_q <= rbe_mem[rbe_raddr];
		end
	end

	// column-to-block table
	always_ff @(posedge clk) begin
		if (wr_col) begin
			cb_mem[in_index[CW-1:0]] <= in_value[BW-1:0];
		end
		if (cmd.latch) begin
			cb_rd_q <= cb_mem[in_column[CW-1:0]];
		end
	end

	// last row block per diagonal, valid bit on top
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			last_mem[clr_addr_q] <= '0;
		end else if (cmd.upd && is_new) begin
			last_mem[k_q] <= {1'b1, l_q};
		end
		if (cmd.look) begin
			last_rd_q <= last_mem[k_d];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			row_q <= in_row;
			col_q <= in_column;
		end
		if (cmd.latch) begin
			l_q <= ptr_q;
		end else if (cmd.scan_step) begin
			l_q <= l_q + BW'(1);
		end
		if (cmd.look) begin
			k_q <= k_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			count_q    <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				ptr_q      <= '0;
				count_q    <= '0;
				clr_addr_q <= stat.clr_done ? '0 : clr_addr_q + BW'(1);
			end else begin
				if (cmd.set_ptr) begin
					ptr_q <= l_q;
				end
				if (cmd.upd) begin
					count_q <= count_d;
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.res_kind)
				RES_OK: begin
					nb_q      <= is_new;
					diag_q    <= DIAG_W'(k_q);
					rb_q      <= RB_W'(l_q);
					cnt_out_q <= count_d;
					err_q     <= 1'b0;
				end
				RES_L_ERR: begin
					nb_q      <= 1'b0;
					diag_q    <= '0;
					rb_q      <= RB_W'(l_q);
					cnt_out_q <= count_q;
					err_q     <= 1'b1;
				end
				RES_PTR_ERR: begin
					nb_q      <= 1'b0;
					diag_q    <= '0;
					rb_q      <= RB_W'(ptr_q);
					cnt_out_q <= count_q;
					err_q     <= 1'b1;
				end
				default: begin
					nb_q      <= 1'b0;
					diag_q    <= '0;
					rb_q      <= RB_W'(ptr_q);
					cnt_out_q <= count_q;
					err_q     <= 1'b0;
				end
			endcase
		end
	end

	assign out_data = {2'b00, err_q, cnt_out_q, rb_q, diag_q, nb_q};

endmodule

/* design/block_diagonal_occupancy_counter_core.sv */
// nonzero entry: accept reads the tables, S_SCAN steps once per row block skipped, S_UPD emits
// table loads: written on accept, result from S_FIN; clear: S_CLR sweeps the diagonal store, then S_FIN
// throughput is set by the row-block end table read loop and the diagonal store read-modify-write
// after arst_n the diagonal store is swept to none with s_tready low
// tables other than the diagonal store hold no defined value until loaded
// top level: bdoc_ctrl and bdoc_dpath, depends on bdoc_pkg
module block_diagonal_occupancy_counter_core #(
	parameter int MAX_BLOCKS  = bdoc_pkg::DEF_MAX_BLOCKS,
	parameter int MAX_COLUMNS = bdoc_pkg::DEF_MAX_COLUMNS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// entry_index, entry_value, row, column, zero pad
	input  logic [bdoc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// op
	input  logic [bdoc_pkg::OP_W-1:0]        s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// new_block, diagonal, row_block, filled_count, error, zero pad
	output logic [bdoc_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import bdoc_pkg::*;

	bdoc_cmd_t  cmd;
	bdoc_stat_t stat;

	bdoc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bdoc_dpath #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (s_tuser),
		.in_index  (s_tdata[15:0]),
		.in_value  (s_tdata[32:16]),
		.in_row    (s_tdata[48:33]),
		.in_column (s_tdata[64:49]),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

endmodule

/* verif/bdoc_occupancy_checker.sv */
`timescale 1ns / 1ps
// stream checker for block_diagonal_occupancy_counter_core: tracks the row-block, column
// and diagonal tables from the accepted input words and compares every result word
// depends on bdoc_pkg
module bdoc_occupancy_checker #(
	parameter int MAX_BLOCKS  = bdoc_pkg::DEF_MAX_BLOCKS,
	parameter int MAX_COLUMNS = bdoc_pkg::DEF_MAX_COLUMNS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// entry_index, entry_value, row, column, zero pad
	input  logic [bdoc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// op
	input  logic [bdoc_pkg::OP_W-1:0]        s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// new_block, diagonal, row_block, filled_count, error, zero pad
	input  logic [bdoc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                               fail_count,
	output int                               outstanding
);
	import bdoc_pkg::*;

	typedef struct packed {
		logic               error;
		logic [COUNT_W-1:0] filled_count;
		logic [RB_W-1:0]    row_block;
		logic [DIAG_W-1:0]  diagonal;
		logic               new_block;
	} occupancy_word_t;

	localparam int VAL_LSB = IDX_W;
	localparam int ROW_LSB = IDX_W + VAL_W;
	localparam int COL_LSB = IDX_W + VAL_W + ROW_W;

	logic [VAL_W-1:0]   row_end_tbl [MAX_BLOCKS];
	logic [RB_W-1:0]    col_block_tbl [MAX_COLUMNS];
	logic [RB_W:0]      last_rb_tbl [MAX_BLOCKS];
	int                 row_ptr;
	logic [COUNT_W-1:0] block_total;
	occupancy_word_t    awaited_occupancy [$];

	function automatic occupancy_word_t count_occupancy(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
			input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		occupancy_word_t w;
		int l;
		int c;
		logic [RB_W:0] l_tag;
		w = '0;
		case (op)
		OP_CLEAR: begin
			foreach (last_rb_tbl[i]) last_rb_tbl[i] = '1;
			row_ptr = 0;
			block_total = '0;
		end
		OP_LOAD_END: begin
			if (idx < MAX_BLOCKS) row_end_tbl[idx] = val;
		end
		OP_LOAD_COL: begin
			if (idx < MAX_COLUMNS && val < MAX_BLOCKS) col_block_tbl[idx] = RB_W'(val);
		end
		OP_ENTRY: begin
			l = row_ptr;
			while (l < MAX_BLOCKS && row_end_tbl[l] <= row) l++;
			if (l >= MAX_BLOCKS || col >= MAX_COLUMNS) begin
				w.error = 1'b1;
			end else begin
				row_ptr = l;
				c = int'(col_block_tbl[col]);
				l_tag = {1'b0, RB_W'(l)};
				if (c < l) begin
					w.error = 1'b1;
				end else begin
					w.diagonal = DIAG_W'(c - l);
					if (last_rb_tbl[c - l] != l_tag) begin
						w.new_block = 1'b1;
						last_rb_tbl[c - l] = l_tag;
						if (block_total != '1) block_total++;
					end
				end
			end
		end
		endcase
		w.row_block = RB_W'(row_ptr);
		w.filled_count = block_total;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		occupancy_word_t got;
		occupancy_word_t want;
		if (!arst_n) begin
			foreach (last_rb_tbl[i]) last_rb_tbl[i] = '1;
			row_ptr = 0;
			block_total = '0;
			awaited_occupancy.delete();
			fail_count = 0;
		end else begin
			if (s_tvalid && s_tready)
				awaited_occupancy.push_back(count_occupancy(s_tuser, s_tdata[IDX_W-1:0],
					s_tdata[VAL_LSB +: VAL_W], s_tdata[ROW_LSB +: ROW_W],
					s_tdata[COL_LSB +: COL_W]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(occupancy_word_t)-1:0];
				if (awaited_occupancy.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result word nb=%0d diag=%0d rb=%0d cnt=%0d err=%0d",
							$time, got.new_block, got.diagonal, got.row_block,
							got.filled_count, got.error);
					fail_count++;
				end else begin
					want = awaited_occupancy.pop_front();
					if (got.new_block !== want.new_block || got.diagonal !== want.diagonal ||
							got.row_block !== want.row_block ||
							got.filled_count !== want.filled_count || got.error !== want.error) begin
						if (fail_count < 10) begin
							$display("%0t: mismatch expected nb=%0d diag=%0d rb=%0d cnt=%0d err=%0d",
								$time, want.new_block, want.diagonal, want.row_block,
								want.filled_count, want.error);
							$display("%0t:               got nb=%0d diag=%0d rb=%0d cnt=%0d err=%0d",
								$time, got.new_block, got.diagonal, got.row_block,
								got.filled_count, got.error);
						end
						fail_count++;
					end
				end
			end
		end
		outstanding = awaited_occupancy.size();
	end

endmodule

/* verif/tb_block_diagonal_occupancy_counter_core.sv */
`timescale 1ns / 1ps
// testbench top for block_diagonal_occupancy_counter_core: clock, reset, stimulus, verdict
// result words are checked by bdoc_occupancy_checker; depends on bdoc_pkg and the design
module tb_block_diagonal_occupancy_counter_core;
	import bdoc_pkg::*;

	localparam int MAX_BLOCKS     = DEF_MAX_BLOCKS;
	localparam int MAX_COLUMNS    = DEF_MAX_COLUMNS;
	localparam int ROW_BLOCKS     = 64;
	localparam int ROWS_PER_BLOCK = 1024;
	localparam int PHASE_WORDS    = 190;
	localparam int QUIET_LIMIT    = 20000;
	localparam int HOLD_CYCLES    = 400;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]        s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	int                     fail_count;
	int                     outstanding;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int words_sent = 0;
	int col_shadow [int];
	int loaded_cols [$];

	block_diagonal_occupancy_counter_core #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.MAX_COLUMNS(MAX_COLUMNS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	bdoc_occupancy_checker #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.MAX_COLUMNS(MAX_COLUMNS)
	) occ_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("block_diagonal_occupancy_counter_core verification failed");
		$finish;
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_TDATA_W'({col, row, val, idx});
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	task automatic load_column(input int col, input int blk);
		send_word(OP_LOAD_COL, IDX_W'(col), VAL_W'(blk), ROW_W'($urandom), COL_W'($urandom));
		if (col < MAX_COLUMNS && blk < MAX_BLOCKS) begin
			if (!col_shadow.exists(col)) loaded_cols.push_back(col);
			col_shadow[col] = blk;
		end
	endtask

	task automatic load_row_end(input int blk, input int end_row);
		send_word(OP_LOAD_END, IDX_W'(blk), VAL_W'(end_row), ROW_W'($urandom), COL_W'($urandom));
	endtask

	task automatic send_entry(input int row, input int col);
		send_word(OP_ENTRY, IDX_W'($urandom), VAL_W'($urandom), ROW_W'(row), COL_W'(col));
	endtask

	task automatic send_clear();
		send_word(OP_CLEAR, IDX_W'($urandom), VAL_W'($urandom), ROW_W'($urandom),
			COL_W'($urandom));
	endtask

	// mostly a column loaded lately, so its block sits near the current row block
	function automatic int recent_column();
		int span;
		if ($urandom_range(0, 3) == 0)
			return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
		span = (loaded_cols.size() < 8) ? loaded_cols.size() : 8;
		return loaded_cols[loaded_cols.size() - 1 - $urandom_range(0, span - 1)];
	endfunction

	task automatic run_frame();
		int n_steps;
		int row;
		int pick;
		int col;
		int l;
		int c;
		int blk;
		n_steps = $urandom_range(8, 60);
		send_clear();
		row = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2000) : $urandom_range(0, 65535);
		repeat (n_steps) begin
			pick = $urandom_range(0, 99);
			l = row / ROWS_PER_BLOCK;
			if (pick < 40 || loaded_cols.size() == 0) begin
				col = $urandom_range(0, 65535);
				c = ($urandom_range(0, 3) == 0) ? $urandom_range(l, MAX_BLOCKS - 1)
					: l + $urandom_range(0, 6);
				if (c >= MAX_BLOCKS) c = MAX_BLOCKS - 1;
				load_column(col, c);
				send_entry(row, col);
			end else if (pick < 80) begin
				send_entry(row, recent_column());
			end else if (pick < 86) begin
				// row at or before the current row
				send_entry($urandom_range(0, row), recent_column());
			end else if (pick < 89) begin
				// largest row, lands in the last row block in use
				send_entry(65535, recent_column());
			end else begin
				case ($urandom_range(0, 3))
				0: load_row_end($urandom_range(MAX_BLOCKS, 65535), $urandom_range(0, 131071));
				1: begin
					blk = $urandom_range(0, ROW_BLOCKS - 1);
					load_row_end(blk, (blk + 1) * ROWS_PER_BLOCK);
				end
				2: load_column($urandom_range(0, 65535), $urandom_range(MAX_BLOCKS, 131071));
				default: load_column($urandom_range(0, 65535), $urandom_range(0, MAX_BLOCKS - 1));
				endcase
			end
			row += $urandom_range(0, 400);
			if (row > 65535) row = 65535;
		end
	endtask

	task automatic run_phase(input int idle, input int stall);
		int target;
		idle_pct = idle;
		stall_pct = stall;
		target = words_sent + PHASE_WORDS;
		while (words_sent < target) run_frame();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = OP_CLEAR;
		s_tdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// row blocks in use get an end row, the last one ends past the largest row
		for (int b = 0; b < ROW_BLOCKS; b++)
			load_row_end(b, (b + 1) * ROWS_PER_BLOCK);

		send_clear();
		load_row_end(65535, 131071);
		load_column(65535, MAX_BLOCKS - 1);
		load_column(0, 0);
		load_column(1, MAX_BLOCKS);
		load_column(2, 131071);
		send_entry(0, 0);
		send_entry(0, 0);
		send_entry(63, 65535);
		send_entry(65535, 65535);
		send_entry(65535, 0);
		send_entry(0, 65535);
		send_clear();
		load_column(32768, 512);
		send_entry(5 * ROWS_PER_BLOCK, 32768);
		send_entry(10, 65535);
		send_entry(65535, 32768);
		send_clear();

		hold_left = HOLD_CYCLES;
		run_phase(0, 0);
		run_phase(87, 0);
		run_phase(0, 87);
		run_phase(23, 23);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("block_diagonal_occupancy_counter_core verification clean");
		else
			$display("block_diagonal_occupancy_counter_core verification failed");
		$finish;
	end

endmodule

/* block_diagonal_occupancy_counter_core.f */
design/bdoc_pkg.sv
design/bdoc_ctrl.sv
design/bdoc_dpath.sv
design/block_diagonal_occupancy_counter_core.sv
verif/bdoc_occupancy_checker.sv
verif/tb_block_diagonal_occupancy_counter_core.sv
